// ----- hdl/npcs_pkg.sv -----
package npcs_pkg;

   // command codes carried in the request word
   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_code_type;

   // distance metric
   typedef enum logic [0:0] {
      MODE_RGBA = 1'b0,
      MODE_LAB  = 1'b1
   } mode_type;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMPARE_MODE = 1'b0,
      CSR_ENTRY_COUNT  = 1'b1
   } csr_index_type;

   localparam int LANES  = 4;
   localparam int MAG_W  = 17;
   localparam int SQ_W   = 34;
   localparam int DIST_W = 36;

   typedef struct packed {
      cmd_code_type       command;
      logic [7:0]         entry_index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [14:0]        lightness;
      logic signed [15:0] green_red;
      logic signed [15:0] blue_yellow;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        best_index;
      logic [DIST_W-1:0] best_distance;
   } rsp_word_type;

   typedef struct packed {
      mode_type   compare_mode;
      logic [8:0] entry_count;
   } cfg_type;

   // word after classification by the front end
   typedef struct packed {
      logic         write_ok;
      req_word_type word;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   typedef struct packed {
      logic signed [15:0] blue_yellow;
      logic signed [15:0] green_red;
      logic [14:0]        lightness;
   } lab_type;

endpackage

// ----- hdl/npcs_ram.sv -----
module npcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/npcs_front.sv -----
module npcs_front #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  npcs_pkg::req_word_type       req_word,
   input  logic                         pop,
   output npcs_pkg::queue_head_type     head
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   npcs_pkg::job_type slot_ff [QUEUE_DEPTH];
   npcs_pkg::job_type job_in;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;

   assign busy = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   // loads outside the palette are flagged here and dropped by the back end
   always_comb begin
      job_in.word     = req_word;
      job_in.write_ok = (req_word.command == npcs_pkg::CMD_LOAD) &&
                        ($unsigned(32'(req_word.entry_index)) < $unsigned(32'(PALETTE_DEPTH)));
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];

endmodule

// ----- hdl/npcs_back.sv -----
module npcs_back #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  npcs_pkg::cfg_type        cfg,
   input  npcs_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_strobe,
   output npcs_pkg::rsp_word_type   rsp_word
);

   localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int IW  = (AW > 8) ? AW : 8;
   localparam int LW  = ($clog2(PALETTE_DEPTH + 1) > 9) ? $clog2(PALETTE_DEPTH + 1) : 9;
   localparam int RGBA_W = $bits(npcs_pkg::rgba_type);
   localparam int LAB_W  = $bits(npcs_pkg::lab_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic          valid;
      logic          first;
      logic          last;
      logic [AW-1:0] idx;
   } tag_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [AW-1:0]          last_ff, last_in;
   logic                   rsp_strobe_ff;
   npcs_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   npcs_pkg::req_word_type query_ff;

   logic [8:0]    count_eff;
   logic [LW-1:0] limit;
   logic [LW-1:0] limit_m1;
   logic [AW-1:0] last_idx;

   logic              is_query;
   logic              wr_en;
   logic [IW-1:0]     load_idx;
   npcs_pkg::rgba_type wr_rgba, rd_rgba;
   npcs_pkg::lab_type  wr_lab, rd_lab;
   logic [RGBA_W-1:0] rd_rgba_bits;
   logic [LAB_W-1:0]  rd_lab_bits;
   logic              rd_en;

   tag_type a_tag_ff, b_tag_ff, c_tag_ff, d_tag_ff;
   logic signed [npcs_pkg::MAG_W-1:0] diff [npcs_pkg::LANES];
   logic signed [8:0]                 alpha_diff;
   logic [npcs_pkg::MAG_W-1:0]        mag [npcs_pkg::LANES];
   logic [npcs_pkg::MAG_W-1:0]        b_mag_ff [npcs_pkg::LANES];
   logic [npcs_pkg::SQ_W-1:0]         c_sq_ff [npcs_pkg::LANES];
   logic [npcs_pkg::DIST_W-1:0]       d_sum_ff;

   logic                        take;
   logic                        result_done;
   logic [AW-1:0]               best_idx_ff, win_idx;
   logic [npcs_pkg::DIST_W-1:0] best_dist_ff, win_dist;
   logic [IW-1:0]               win_idx_wide;

   // last index searched: count of zero acts as one, clamp to the depth
   always_comb begin
      count_eff = (cfg.entry_count == 9'd0) ? 9'd1 : cfg.entry_count;
      limit     = (LW'(count_eff) > LW'(PALETTE_DEPTH)) ? LW'(PALETTE_DEPTH) : LW'(count_eff);
      limit_m1  = limit - LW'(1);
      last_idx  = limit_m1[AW-1:0];
   end

   assign is_query = (head.job.word.command == npcs_pkg::CMD_QUERY);
   assign load_idx = IW'(head.job.word.entry_index);
   assign wr_en    = pop && !is_query && head.job.write_ok;
   assign rd_en    = (state_ff == ST_SCAN);

   always_comb begin
      wr_rgba.red         = head.job.word.red;
      wr_rgba.green       = head.job.word.green;
      wr_rgba.blue        = head.job.word.blue;
      wr_rgba.alpha       = head.job.word.alpha;
      wr_lab.lightness    = head.job.word.lightness;
      wr_lab.green_red    = head.job.word.green_red;
      wr_lab.blue_yellow  = head.job.word.blue_yellow;
   end

   npcs_ram #(
      .WIDTH (RGBA_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_rgba_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_idx[AW-1:0]),
      .wr_data (wr_rgba),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_rgba_bits)
   );

   npcs_ram #(
      .WIDTH (LAB_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_lab_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_idx[AW-1:0]),
      .wr_data (wr_lab),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_lab_bits)
   );

   assign rd_rgba = npcs_pkg::rgba_type'(rd_rgba_bits);
   assign rd_lab  = npcs_pkg::lab_type'(rd_lab_bits);

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (is_query) begin
                  addr_in  = '0;
                  last_in  = last_idx;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (result_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // differences, four lanes shared by both metrics
   always_comb begin
      alpha_diff = $signed({1'b0, rd_rgba.alpha}) - $signed({1'b0, query_ff.alpha});
      if (cfg.compare_mode == npcs_pkg::MODE_RGBA) begin
         diff[0] = $signed({9'b0, rd_rgba.red})   - $signed({9'b0, query_ff.red});
         diff[1] = $signed({9'b0, rd_rgba.green}) - $signed({9'b0, query_ff.green});
         diff[2] = $signed({9'b0, rd_rgba.blue})  - $signed({9'b0, query_ff.blue});
         diff[3] = $signed({{8{alpha_diff[8]}}, alpha_diff});
      end else begin
         diff[0] = $signed({2'b0, rd_lab.lightness}) - $signed({2'b0, query_ff.lightness});
         diff[1] = $signed({rd_lab.green_red[15], rd_lab.green_red})
                 - $signed({query_ff.green_red[15], query_ff.green_red});
         diff[2] = $signed({rd_lab.blue_yellow[15], rd_lab.blue_yellow})
                 - $signed({query_ff.blue_yellow[15], query_ff.blue_yellow});
         diff[3] = $signed({alpha_diff, 8'b0});
      end
      for (int i = 0; i < npcs_pkg::LANES; i++) begin
         mag[i] = diff[i][npcs_pkg::MAG_W-1] ? (~diff[i] + npcs_pkg::MAG_W'(1)) : diff[i];
      end
   end

   // running minimum, strict compare keeps the lowest index on ties
   assign take        = d_tag_ff.first || (d_sum_ff < best_dist_ff);
   assign win_idx     = take ? d_tag_ff.idx : best_idx_ff;
   assign win_dist    = take ? d_sum_ff : best_dist_ff;
   assign result_done = d_tag_ff.valid && d_tag_ff.last;
   assign win_idx_wide = IW'(win_idx);

   always_comb begin
      rsp_word_in.best_index    = win_idx_wide[7:0];
      rsp_word_in.best_distance = win_dist;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         last_ff       <= last_in;
         rsp_strobe_ff <= result_done;
         if (result_done) begin
            rsp_word_ff <= rsp_word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
         d_tag_ff <= '0;
      end else begin
         a_tag_ff.valid <= rd_en;
         a_tag_ff.first <= (addr_ff == '0);
         a_tag_ff.last  <= (addr_ff == last_ff);
         a_tag_ff.idx   <= addr_ff;
         b_tag_ff       <= a_tag_ff;
         c_tag_ff       <= b_tag_ff;
         d_tag_ff       <= c_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_query) begin
         query_ff <= head.job.word;
      end
      for (int i = 0; i < npcs_pkg::LANES; i++) begin
         b_mag_ff[i] <= mag[i];
         c_sq_ff[i]  <= b_mag_ff[i] * b_mag_ff[i];
      end
      d_sum_ff <= npcs_pkg::DIST_W'(c_sq_ff[0]) + npcs_pkg::DIST_W'(c_sq_ff[1])
                + npcs_pkg::DIST_W'(c_sq_ff[2]) + npcs_pkg::DIST_W'(c_sq_ff[3]);
      if (d_tag_ff.valid) begin
         best_idx_ff  <= win_idx;
         best_dist_ff <= win_dist;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ----- hdl/nearest_palette_color_search_top.sv -----
// nearest palette color search
//
// request channel: a word is taken at a clock edge where start is high and
// busy is low. command load writes red..alpha and the lab fields into palette
// slot entry_index (slots at or beyond the depth are dropped) and gives no
// result. command query scans slots 0 to N-1, N as below, and returns one word.
// csr port: csr_we writes csr_wdata into compare_mode (index 0, rgba or lab
// metric) or entry_count (index 1); write only while the block is idle.
// response channel: rsp_strobe is high for one cycle with rsp_word holding
// best_index and best_distance; the receiver takes it in that cycle and
// cannot hold it off.
// timing: words enter a two deep queue and leave it when the back end is idle;
// a load is written as it leaves and does not hold the back end. a query scans
// N slots (N is entry_count, zero taken as one, at most the depth) and holds
// the back end until its result passes ram read, difference, square, sum
// stages and running minimum. busy is high only while the queue is full.
// reset: queue empty, no result pending, compare_mode rgba, entry_count 1;
// palette contents stay undefined until loaded.
module nearest_palette_color_search_top #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  npcs_pkg::req_word_type               req_word,
   output logic                                 rsp_strobe,
   output npcs_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_we,
   input  logic [npcs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [npcs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   npcs_pkg::cfg_type        cfg_ff;
   npcs_pkg::queue_head_type head;
   logic                     pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.compare_mode <= npcs_pkg::MODE_RGBA;
         cfg_ff.entry_count  <= 9'd1;
      end else if (csr_we) begin
         unique case (npcs_pkg::csr_index_type'(csr_index))
            npcs_pkg::CSR_COMPARE_MODE: begin
               cfg_ff.compare_mode <= npcs_pkg::mode_type'(csr_wdata[0]);
            end
            npcs_pkg::CSR_ENTRY_COUNT: begin
               cfg_ff.entry_count <= csr_wdata;
            end
         endcase
      end
   end

   // front end: takes and classifies words, queues them
   npcs_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .pop      (pop),
      .head     (head)
   );

   // back end: palette ram, scan sequencer, distance pipe and minimum
   npcs_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ----- hdl/npcs_checker.sv -----
module npcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // results never come in back to back cycles
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in back to back cycles");

   // reset leaves the queue empty and nothing pending
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("result or busy right after reset");

   // the queue only fills through an accepted word
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted word");

   // a query must pass the queue, the scan and the distance pipe, so no result shortly after reset
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!$past(reset) && !$past(reset, 2) && !$past(reset, 3)))
      else $error("result too soon after reset");

endmodule

bind nearest_palette_color_search_top npcs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
